@@ src/u16550_pkg.sv @@
`default_nettype none
package u16550_pkg;

  // Transaction kinds
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_RX    = 2'd2;

  // Register indexes
  localparam logic [4:0] REG_IER = 5'd1;
  localparam logic [4:0] REG_IIR = 5'd2;
  localparam logic [4:0] REG_LCR = 5'd3;
  localparam logic [4:0] REG_MCR = 5'd4;
  localparam logic [4:0] REG_LSR = 5'd5;
  localparam logic [4:0] REG_MSR = 5'd6;
  localparam logic [4:0] REG_SCR = 5'd7;

  // Interrupt enable bits
  localparam int unsigned IER_RDI  = 0;
  localparam int unsigned IER_THRI = 1;
  localparam int unsigned IER_RLSI = 2;

  // Interrupt identity codes
  localparam logic [3:0] IIR_NONE   = 4'h1;
  localparam logic [3:0] IIR_THRI   = 4'h2;
  localparam logic [3:0] IIR_RLSI   = 4'h6;
  localparam logic [3:0] IIR_CTI    = 4'hC;
  localparam logic [3:0] IIR_IDMASK = 4'hE;

  // Line status bits
  localparam int unsigned LSR_DR   = 0;
  localparam int unsigned LSR_OE   = 1;
  localparam int unsigned LSR_BI   = 4;
  localparam int unsigned LSR_THRE = 5;
  localparam int unsigned LSR_TEMT = 6;
  localparam logic [7:0] LSR_ANYERR = 8'h1E;

  localparam int unsigned LCR_DLAB = 7;

  // Reset values
  localparam logic [7:0] IIR_RESET = 8'h01;
  localparam logic [7:0] LSR_RESET = 8'h60;
  localparam logic [7:0] MSR_RESET = 8'hB0;
  localparam logic [7:0] MCR_RESET = 8'h08;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [7:0] iir;
    logic       thre_pending;
  } irq_eval_t;

  // Pick the interrupt identity by priority, keep the upper nibble.
  function automatic irq_eval_t reevaluate(input logic [3:0] ie, input logic [7:0] lsr,
                                           input logic tp, input logic [7:0] iir);
    irq_eval_t  r;
    logic [3:0] code;
    code = IIR_NONE;
    if (ie[IER_RLSI] && ((lsr & LSR_ANYERR) != 8'h00)) begin
      code = IIR_RLSI;
    end else if (ie[IER_RDI] && lsr[LSR_DR]) begin
      code = IIR_CTI;
    end else if (ie[IER_THRI] && tp) begin
      code = IIR_THRI;
    end
    r.iir = {iir[7:4], code};
    r.thre_pending = (code != IIR_NONE) ? 1'b0 : tp;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/uart_16550_register_block.sv @@
// 16550-style UART register block.
// Input channel: drive action_i, reg_index_i and wdata_i with start high;
// the transaction is taken at the rising edge where start is high and busy
// is low. action_i selects a bus write, a bus read or a byte received from
// the line; reg_index_i picks the register (indexes above 7 act as index 0).
// Result channel: done_o is high for exactly one cycle and marks
// read_data_o, tx_valid_o, tx_byte_o and irq_o. The receiver has no way to
// stall; take the result in that cycle.
// Sequence: the controller captures the transaction, executes the register
// update, then presents the result with done_o; busy drops in the cycle after
// the strobe, and no new transaction is taken while busy is high.
// Reset (rst_ni low, asynchronous) returns every UART register to its 16550
// default: IIR reads no interrupt, LSR shows THRE and TEMT, MSR shows DCD,
// DSR and CTS, MCR has OUT2 set; all others read zero.
`default_nettype none
module uart_16550_register_block
  import u16550_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] action_i,
  input  wire logic [4:0] reg_index_i,
  input  wire logic [7:0] wdata_i,
  output logic            done_o,
  output logic [7:0]      read_data_o,
  output logic            tx_valid_o,
  output logic [7:0]      tx_byte_o,
  output logic            irq_o
);

  ctrl_cmd_t cmd;

  // Sequence each transaction: capture, execute, present.
  u16550_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // Hold the register file and compute the result.
  u16550_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .action_i    (action_i),
    .reg_index_i (reg_index_i),
    .wdata_i     (wdata_i),
    .read_data_o (read_data_o),
    .tx_valid_o  (tx_valid_o),
    .tx_byte_o   (tx_byte_o),
    .irq_o       (irq_o)
  );

endmodule
`default_nettype wire

@@ src/u16550_ctrl.sv @@
`default_nettype none
module u16550_ctrl
  import u16550_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  output logic       busy_o,
  output logic       done_o,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

endmodule
`default_nettype wire

@@ src/u16550_dp.sv @@
`default_nettype none
module u16550_dp
  import u16550_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire ctrl_cmd_t  cmd_i,
  input  wire logic [1:0] action_i,
  input  wire logic [4:0] reg_index_i,
  input  wire logic [7:0] wdata_i,
  output logic [7:0]      read_data_o,
  output logic            tx_valid_o,
  output logic [7:0]      tx_byte_o,
  output logic            irq_o
);

  // Captured transaction
  logic [1:0] act_q;
  logic [4:0] idx_q;
  logic [7:0] wd_q;

  // Register file
  logic [7:0] rbr_q, rbr_d, thr_q, thr_d, iir_q, iir_d, lcr_q, lcr_d;
  logic [7:0] lsr_q, lsr_d, msr_q, msr_d, mcr_q, mcr_d, scr_q, scr_d;
  logic [7:0] fcr_q, fcr_d, dll_q, dll_d, dlh_q, dlh_d;
  logic [3:0] ier_q, ier_d;
  logic       tp_q, tp_d, tp_pre;

  // Result
  logic [7:0] rd_q, rd_d, txb_q, txb_d;
  logic       txv_q, txv_d, irq_q;

  logic       dlab, eval;
  irq_eval_t  ev_r;

  assign dlab = lcr_q[LCR_DLAB];

  always_comb begin
    rbr_d = rbr_q; thr_d = thr_q; lcr_d = lcr_q;
    lsr_d = lsr_q; msr_d = msr_q; mcr_d = mcr_q; scr_d = scr_q;
    fcr_d = fcr_q; dll_d = dll_q; dlh_d = dlh_q; ier_d = ier_q;
    tp_pre = tp_q;
    rd_d = 8'h00; txv_d = 1'b0; txb_d = 8'h00;
    eval = 1'b0;
    case (act_q)
      ACT_WRITE: begin
        case (idx_q)
          REG_IER: begin
            if (dlab) begin
              dlh_d = wd_q;
            end else begin
              ier_d = wd_q[3:0];
              eval  = lsr_q[LSR_THRE];
            end
          end
          REG_IIR: fcr_d = wd_q;
          REG_LCR: lcr_d = wd_q;
          REG_MCR: mcr_d = wd_q;
          REG_LSR, REG_MSR: ;
          REG_SCR: scr_d = wd_q;
          default: begin
            if (dlab) begin
              dll_d = wd_q;
            end else begin
              thr_d = wd_q;
              lsr_d[LSR_THRE] = 1'b1;
              lsr_d[LSR_TEMT] = 1'b1;
              tp_pre = 1'b1;
              txv_d  = 1'b1;
              txb_d  = wd_q;
              eval   = 1'b1;
            end
          end
        endcase
      end
      ACT_READ: begin
        case (idx_q)
          REG_IER: rd_d = dlab ? dlh_q : {4'h0, ier_q};
          REG_IIR: begin
            rd_d = iir_q;
            if ((iir_q[3:0] & IIR_IDMASK) == IIR_THRI) begin
              tp_pre = 1'b0;
              eval   = 1'b1;
            end
          end
          REG_LCR: rd_d = lcr_q;
          REG_MCR: rd_d = mcr_q;
          REG_LSR: begin
            rd_d = lsr_q;
            if (lsr_q[LSR_BI] || lsr_q[LSR_OE]) begin
              lsr_d[LSR_BI] = 1'b0;
              lsr_d[LSR_OE] = 1'b0;
              eval = 1'b1;
            end
          end
          REG_MSR: begin
            rd_d  = msr_q;
            msr_d = {msr_q[7:4], 4'h0};
          end
          REG_SCR: rd_d = scr_q;
          default: begin
            if (dlab) begin
              rd_d = dll_q;
            end else begin
              rd_d = rbr_q;
              lsr_d[LSR_DR] = 1'b0;
              eval = 1'b1;
            end
          end
        endcase
      end
      ACT_RX: begin
        rbr_d = wd_q;
        lsr_d[LSR_DR] = 1'b1;
        eval = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    ev_r  = reevaluate(ier_d, lsr_d, tp_pre, iir_q);
    iir_d = eval ? ev_r.iir : iir_q;
    tp_d  = eval ? ev_r.thre_pending : tp_pre;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      idx_q <= reg_index_i;
      wd_q  <= wdata_i;
    end
    if (cmd_i.exec) begin
      rd_q  <= rd_d;
      txb_q <= txb_d;
      txv_q <= txv_d;
      irq_q <= (iir_d[3:0] != IIR_NONE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rbr_q <= 8'h00; thr_q <= 8'h00; ier_q <= 4'h0; iir_q <= IIR_RESET;
      lcr_q <= 8'h00; lsr_q <= LSR_RESET; msr_q <= MSR_RESET; mcr_q <= MCR_RESET;
      scr_q <= 8'h00; fcr_q <= 8'h00; dll_q <= 8'h00; dlh_q <= 8'h00;
      tp_q  <= 1'b0;
    end else if (cmd_i.exec) begin
      rbr_q <= rbr_d; thr_q <= thr_d; ier_q <= ier_d; iir_q <= iir_d;
      lcr_q <= lcr_d; lsr_q <= lsr_d; msr_q <= msr_d; mcr_q <= mcr_d;
      scr_q <= scr_d; fcr_q <= fcr_d; dll_q <= dll_d; dlh_q <= dlh_d;
      tp_q  <= tp_d;
    end
  end

  assign read_data_o = rd_q;
  assign tx_valid_o  = txv_q;
  assign tx_byte_o   = txb_q;
  assign irq_o       = irq_q;

endmodule
`default_nettype wire

@@ tb/sv/uart_16550_register_block_test.sv @@
module uart_16550_register_block_test
  import u16550_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Data register index (RBR/THR/DLL) and the do-nothing action code.
  localparam logic [4:0] REG_DATA = 5'd0;
  localparam logic [1:0] ACT_NOP  = 2'd3;

  localparam int RANDOM_ITEMS = 1700;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq;
  } uart_result_t;

  typedef struct packed {
    logic [1:0]   act;
    logic [4:0]   idx;
    logic [7:0]   data;
    logic         fixed;
    uart_result_t fixed_res;
  } script_row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       start       = 1'b0;
  logic [1:0] action_i    = ACT_NOP;
  logic [4:0] reg_index_i = REG_DATA;
  logic [7:0] wdata_i     = 8'h00;
  logic       busy;
  logic       done_o;
  logic [7:0] read_data_o;
  logic       tx_valid_o;
  logic [7:0] tx_byte_o;
  logic       irq_o;

  uart_16550_register_block uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .action_i    (action_i),
    .reg_index_i (reg_index_i),
    .wdata_i     (wdata_i),
    .done_o      (done_o),
    .read_data_o (read_data_o),
    .tx_valid_o  (tx_valid_o),
    .tx_byte_o   (tx_byte_o),
    .irq_o       (irq_o)
  );

  // 50 MHz clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Register file mirror: updated in acceptance order, one access at a time.
  // ---------------------------------------------------------------------------
  logic [7:0] rbr_q, thr_q, iir_q, lcr_q, lsr_q, msr_q, mcr_q, scr_q, fcr_q, dll_q, dlh_q;
  logic [3:0] ier_q;
  logic       thre_pend_q;

  uart_result_t awaited_results [$];
  script_row_t  script [$];
  int           fail_count   = 0;
  int           stall_cycles = 0;
  bit           quiet_mode   = 1'b0;
  uart_result_t seen_res, want_res;

  task automatic mirror_reset();
    rbr_q       = 8'h00;
    thr_q       = 8'h00;
    ier_q       = 4'h0;
    iir_q       = IIR_RESET;
    lcr_q       = 8'h00;
    lsr_q       = LSR_RESET;
    msr_q       = MSR_RESET;
    mcr_q       = MCR_RESET;
    scr_q       = 8'h00;
    fcr_q       = 8'h00;
    dll_q       = 8'h00;
    dlh_q       = 8'h00;
    thre_pend_q = 1'b0;
  endtask

  // Priority: line status errors, then received data, then a pending THR empty.
  // Any active source drops the pending THR empty event.
  task automatic refresh_int_ident();
    logic [3:0] code;
    code = IIR_NONE;
    if (ier_q[IER_RLSI] && ((lsr_q & LSR_ANYERR) != 8'h00)) begin
      code = IIR_RLSI;
    end else if (ier_q[IER_RDI] && lsr_q[LSR_DR]) begin
      code = IIR_CTI;
    end else if (ier_q[IER_THRI] && thre_pend_q) begin
      code = IIR_THRI;
    end
    iir_q = {iir_q[7:4], code};
    if (code != IIR_NONE) begin
      thre_pend_q = 1'b0;
    end
  endtask

  task automatic predict_access(input logic [1:0] act, input logic [4:0] idx,
                                input logic [7:0] d, output uart_result_t r);
    logic dlab;
    dlab = lcr_q[LCR_DLAB];
    r = '0;
    case (act)
      ACT_WRITE: begin
        case (idx)
          REG_IER: begin
            if (dlab) begin
              dlh_q = d;
            end else begin
              ier_q = d[3:0];
              if (lsr_q[LSR_THRE]) begin
                refresh_int_ident();
              end
            end
          end
          REG_IIR: fcr_q = d;
          REG_LCR: lcr_q = d;
          REG_MCR: mcr_q = d;
          REG_LSR, REG_MSR: ;
          REG_SCR: scr_q = d;
          default: begin
            if (dlab) begin
              dll_q = d;
            end else begin
              thr_q           = d;
              lsr_q[LSR_THRE] = 1'b1;
              lsr_q[LSR_TEMT] = 1'b1;
              thre_pend_q     = 1'b1;
              r.tx_valid      = 1'b1;
              r.tx_byte       = d;
              refresh_int_ident();
            end
          end
        endcase
      end
      ACT_READ: begin
        case (idx)
          REG_IER: r.read_data = dlab ? dlh_q : {4'h0, ier_q};
          REG_IIR: begin
            r.read_data = iir_q;
            if ((iir_q[3:0] & IIR_IDMASK) == IIR_THRI) begin
              thre_pend_q = 1'b0;
              refresh_int_ident();
            end
          end
          REG_LCR: r.read_data = lcr_q;
          REG_MCR: r.read_data = mcr_q;
          REG_LSR: begin
            r.read_data = lsr_q;
            if (lsr_q[LSR_BI] || lsr_q[LSR_OE]) begin
              lsr_q[LSR_BI] = 1'b0;
              lsr_q[LSR_OE] = 1'b0;
              refresh_int_ident();
            end
          end
          REG_MSR: begin
            r.read_data = msr_q;
            msr_q[3:0]  = 4'h0;
          end
          REG_SCR: r.read_data = scr_q;
          default: begin
            if (dlab) begin
              r.read_data = dll_q;
            end else begin
              r.read_data   = rbr_q;
              lsr_q[LSR_DR] = 1'b0;
              refresh_int_ident();
            end
          end
        endcase
      end
      ACT_RX: begin
        rbr_q         = d;
        lsr_q[LSR_DR] = 1'b1;
        refresh_int_ident();
      end
      default: ;
    endcase
    r.irq = (iir_q[3:0] != IIR_NONE);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: idle for a random gap, raise start with the payload, hold it until
  // busy is low at a rising edge, then log the predicted transaction result.
  // ---------------------------------------------------------------------------
  task automatic send_access(input logic [1:0] act, input logic [4:0] idx,
                             input logic [7:0] d, input logic fixed,
                             input uart_result_t fixed_res);
    int           gap;
    uart_result_t r;
    gap = quiet_mode ? 0 : $urandom_range(4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    action_i    <= act;
    reg_index_i <= idx;
    wdata_i     <= d;
    do @(posedge clk_i); while (busy);
    predict_access(act, idx, d, r);
    awaited_results.push_back(fixed ? fixed_res : r);
  endtask

  task automatic add_row(input logic [1:0] act, input logic [4:0] idx, input logic [7:0] d,
                         input logic fixed, input logic [7:0] rd, input logic txv,
                         input logic [7:0] txb, input logic irq);
    script_row_t row;
    row.act       = act;
    row.idx       = idx;
    row.data      = d;
    row.fixed     = fixed;
    row.fixed_res = {rd, txv, txb, irq};
    script.push_back(row);
  endtask

  // Draw a random access: mostly defined registers, sometimes the aliased
  // upper indexes; keep DLAB clear most of the time so the data path stays live.
  task automatic draw_access(output logic [1:0] act, output logic [4:0] idx,
                             output logic [7:0] d);
    int pick;
    pick = $urandom_range(99);
    if (pick < 40)      act = ACT_WRITE;
    else if (pick < 80) act = ACT_READ;
    else if (pick < 95) act = ACT_RX;
    else                act = ACT_NOP;
    idx = ($urandom_range(99) < 85) ? 5'($urandom_range(7)) : 5'($urandom_range(31, 8));
    case ($urandom_range(9))
      0:       d = 8'h00;
      1:       d = 8'hFF;
      default: d = 8'($urandom_range(255));
    endcase
    if (act == ACT_WRITE && idx == REG_LCR && $urandom_range(3) != 0) begin
      d[LCR_DLAB] = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobe must match the oldest logged transaction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      seen_res = {read_data_o, tx_valid_o, tx_byte_o, irq_o};
      if (awaited_results.size() == 0) begin
        $display("%0t: result with nothing outstanding: read_data %h tx_valid %b tx_byte %h irq %b",
                 $realtime, read_data_o, tx_valid_o, tx_byte_o, irq_o);
        fail_count++;
      end else begin
        want_res = awaited_results.pop_front();
        if (seen_res.read_data !== want_res.read_data) begin
          $display("%0t: read_data expected %h actual %h",
                   $realtime, want_res.read_data, seen_res.read_data);
          fail_count++;
        end
        if (seen_res.tx_valid !== want_res.tx_valid) begin
          $display("%0t: tx_valid expected %b actual %b",
                   $realtime, want_res.tx_valid, seen_res.tx_valid);
          fail_count++;
        end
        if (seen_res.tx_byte !== want_res.tx_byte) begin
          $display("%0t: tx_byte expected %h actual %h",
                   $realtime, want_res.tx_byte, seen_res.tx_byte);
          fail_count++;
        end
        if (seen_res.irq !== want_res.irq) begin
          $display("%0t: irq expected %b actual %b", $realtime, want_res.irq, seen_res.irq);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles in which neither side moves a transaction.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [1:0] act;
    logic [4:0] idx;
    logic [7:0] d;

    mirror_reset();

    // Reset values of every register readable with DLAB clear, with the results typed in.
    add_row(ACT_READ,  REG_LCR,  8'h00, 1'b1, 8'h00,     1'b0, 8'h00, 1'b0);
    add_row(ACT_READ,  REG_IER,  8'h00, 1'b1, 8'h00,     1'b0, 8'h00, 1'b0);
    add_row(ACT_READ,  REG_IIR,  8'h00, 1'b1, IIR_RESET, 1'b0, 8'h00, 1'b0);
    add_row(ACT_READ,  REG_MCR,  8'h00, 1'b1, MCR_RESET, 1'b0, 8'h00, 1'b0);
    add_row(ACT_READ,  REG_LSR,  8'h00, 1'b1, LSR_RESET, 1'b0, 8'h00, 1'b0);
    add_row(ACT_READ,  REG_MSR,  8'h00, 1'b1, MSR_RESET, 1'b0, 8'h00, 1'b0);
    add_row(ACT_READ,  REG_SCR,  8'h00, 1'b1, 8'h00,     1'b0, 8'h00, 1'b0);
    add_row(ACT_READ,  REG_DATA, 8'h00, 1'b1, 8'h00,     1'b0, 8'h00, 1'b0);
    // Transmit with interrupts masked: byte goes out, line stays low.
    add_row(ACT_WRITE, REG_DATA, 8'hFF, 1'b1, 8'h00,     1'b1, 8'hFF, 1'b0);
    // Enable all sources: the pending THR empty event raises the line,
    // and reading IIR clears it again.
    add_row(ACT_WRITE, REG_IER,  8'h0F, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(ACT_READ,  REG_IIR,  8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    // Received data raises the CTI code (0xC); FCR write lands, IIR reads back.
    add_row(ACT_RX,    REG_DATA, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(ACT_WRITE, REG_IIR,  8'hFF, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(ACT_READ,  REG_IIR,  8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    // Highest index aliases RBR and clears DR.
    add_row(ACT_READ,  5'd31,    8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    // Writes to LSR and MSR are dropped.
    add_row(ACT_WRITE, REG_LSR,  8'hFF, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(ACT_WRITE, REG_MSR,  8'hFF, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    // Divisor latches behind DLAB.
    add_row(ACT_WRITE, REG_LCR,  8'h80, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(ACT_WRITE, REG_DATA, 8'hA5, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(ACT_WRITE, REG_IER,  8'h5A, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(ACT_READ,  REG_DATA, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(ACT_READ,  REG_IER,  8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(ACT_WRITE, REG_LCR,  8'h7F, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    // Aliased index transmits; scratch, MCR cleared, idle action, RX extreme.
    add_row(ACT_WRITE, 5'd16,    8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(ACT_WRITE, REG_SCR,  8'hFF, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(ACT_WRITE, REG_MCR,  8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(ACT_NOP,   REG_DATA, 8'hFF, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(ACT_RX,    REG_DATA, 8'hFF, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);

    // Hold reset, then release it for good.
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      send_access(script[i].act, script[i].idx, script[i].data,
                  script[i].fixed, script[i].fixed_res);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Switch between gapped and back-to-back stretches.
      if (n % 100 == 0) begin
        quiet_mode = ($urandom_range(2) == 0);
      end
      // Halfway through, drop start and drain every outstanding transaction.
      if (n == RANDOM_ITEMS / 2) begin
        start <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      draw_access(act, idx, d);
      send_access(act, idx, d, 1'b0, '0);
    end
    start <= 1'b0;

    // Drain, then keep watching for any stray strobe before the verdict.
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
